@@ design/tlca_pkg.sv @@
package tlca_pkg;

    localparam int NODE_BITS  = 22;
    localparam int TAXON_BITS = NODE_BITS + 1;
    localparam int MAX_DEPTH  = 100;
    localparam int IDX_W      = $clog2(MAX_DEPTH);
    localparam int CNT_W      = $clog2(MAX_DEPTH + 1);

    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_LCA   = 2'd1;
    localparam logic [1:0] REQ_BLACK = 2'd2;

    typedef struct packed {
        logic                 en;
        logic [NODE_BITS-1:0] addr;
        logic [NODE_BITS-1:0] parent;
        logic                 allowed;
    } t_tbl_wr;

endpackage

@@ design/tlca_table.sv @@
module tlca_table (
    input  logic                          i_clk,
    input  tlca_pkg::t_tbl_wr             i_wr,
    input  logic [tlca_pkg::NODE_BITS-1:0] i_rd_addr,
    output logic [tlca_pkg::NODE_BITS-1:0] o_rd_parent,
    output logic                          o_rd_allowed
);

    localparam int DEPTH = 1 << tlca_pkg::NODE_BITS;

    logic [tlca_pkg::NODE_BITS-1:0] r_parent_mem [DEPTH];
    logic                           r_allowed_mem [DEPTH];
    logic [tlca_pkg::NODE_BITS-1:0] r_rd_parent;
    logic                           r_rd_allowed;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_parent_mem[i_wr.addr]  <= i_wr.parent;
            r_allowed_mem[i_wr.addr] <= i_wr.allowed;
        end
        r_rd_parent  <= r_parent_mem[i_rd_addr];
        r_rd_allowed <= r_allowed_mem[i_rd_addr];
    end

    assign o_rd_parent  = r_rd_parent;
    assign o_rd_allowed = r_rd_allowed;

endmodule

@@ design/taxonomy_lca_engine.sv @@
// Taxonomy lowest common ancestor engine.
// Input channel (i_in_valid / o_in_stall) carries one request per transfer:
// a node write, a common ancestor query or a blacklist query. Output channel
// (o_out_valid / i_out_stall) returns exactly one result per request, in order.
// max_node is loaded through i_cfg_wr_en / i_cfg_wr_data; the user must load
// it only while the block idles, which the block does not enforce. One request
// is worked on at a time; o_in_stall is high until its result is registered.
// A node write, an unknown request type or an out of range query goes straight
// to the finish state; an early answer on parent(b) reads parent(b) first.
// Otherwise the parent table is read through one port, one node per cycle: a
// common ancestor query walks the lineages of a and b (la, lb: lineage lengths
// up to 100), then compares them from the root end (m: compare steps up to
// 100); a blacklist query walks the lineage of a.
// The result sits in an output register, so a new request is taken while the
// previous result waits; if the receiver stalls the result holds there and the
// next result waits in the engine until the register frees.
// Reset clears the sequencer, the output valid and sets max_node to all ones;
// table contents are not cleared and must be written before they are read.
module taxonomy_lca_engine (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_wr_en,
    input  logic [tlca_pkg::NODE_BITS-1:0]         i_cfg_wr_data,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic [1:0]                             i_req_type,
    input  logic [tlca_pkg::NODE_BITS-1:0]         i_node_id,
    input  logic [tlca_pkg::NODE_BITS-1:0]         i_parent_id,
    input  logic                                   i_node_allowed,
    input  logic signed [tlca_pkg::TAXON_BITS-1:0] i_taxon_a,
    input  logic [tlca_pkg::NODE_BITS-1:0]         i_taxon_b,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [tlca_pkg::TAXON_BITS-1:0] o_ancestor_id,
    output logic                                   o_range_error,
    output logic                                   o_is_blacklisted
);

    localparam int NB = tlca_pkg::NODE_BITS;
    localparam int TB = tlca_pkg::TAXON_BITS;
    localparam int IW = tlca_pkg::IDX_W;
    localparam int CW = tlca_pkg::CNT_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CHKB = 3'd1;
    localparam logic [2:0] S_WALK = 3'd2;
    localparam logic [2:0] S_CMP  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]          r_state, n_state;
    logic [NB-1:0]       r_max_node;
    logic                r_sel, n_sel;
    logic                r_blk, n_blk;
    logic [CW-1:0]       r_n, n_n;
    logic [CW-1:0]       r_la, n_la;
    logic [CW-1:0]       r_m, n_m;
    logic [IW-1:0]       r_ia, n_ia;
    logic [IW-1:0]       r_ib, n_ib;
    logic [NB-1:0]       r_t, n_t;
    logic [TB-1:0]       r_a, n_a;
    logic [NB-1:0]       r_b, n_b;
    logic [TB-1:0]       r_anc, n_anc;
    logic                r_err, n_err;
    logic                r_bl, n_bl;
    logic                r_out_valid, n_out_valid;
    logic [TB-1:0]       r_out_anc;
    logic                r_out_err;
    logic                r_out_bl;

    logic [NB-1:0]       r_lin_a [tlca_pkg::MAX_DEPTH];
    logic [NB-1:0]       r_lin_b [tlca_pkg::MAX_DEPTH];
    logic [NB-1:0]       r_xa, r_xb;

    tlca_pkg::t_tbl_wr   tbl_wr;
    logic [NB-1:0]       tbl_addr;
    logic [NB-1:0]       tbl_parent;
    logic                tbl_allowed;

    logic                in_acc;
    logic                fin_fire;
    logic                a_neg;
    logic                step_go;
    logic                lin_we_a, lin_we_b;
    logic [CW-1:0]       m_len;

    tlca_table u_table (
        .i_clk       (i_clk),
        .i_wr        (tbl_wr),
        .i_rd_addr   (tbl_addr),
        .o_rd_parent (tbl_parent),
        .o_rd_allowed(tbl_allowed)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign fin_fire   = (r_state == S_FIN) && (!r_out_valid || !i_out_stall);
    assign a_neg      = i_taxon_a[TB-1];
    assign step_go    = (r_n < CW'(tlca_pkg::MAX_DEPTH)) && (tbl_parent != r_t);
    assign m_len      = (r_la < r_n) ? r_la : r_n;

    always_comb begin
        tbl_wr.en      = in_acc && (i_req_type == tlca_pkg::REQ_WRITE);
        tbl_wr.addr    = i_node_id;
        tbl_wr.parent  = i_parent_id;
        tbl_wr.allowed = i_node_allowed;
    end

    always_comb begin
        n_state  = r_state;
        n_sel    = r_sel;
        n_blk    = r_blk;
        n_n      = r_n;
        n_la     = r_la;
        n_m      = r_m;
        n_ia     = r_ia;
        n_ib     = r_ib;
        n_t      = r_t;
        n_a      = r_a;
        n_b      = r_b;
        n_anc    = r_anc;
        n_err    = r_err;
        n_bl     = r_bl;
        tbl_addr = r_t;
        lin_we_a = 1'b0;
        lin_we_b = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_anc   = '0;
                    n_err   = 1'b0;
                    n_bl    = 1'b0;
                    n_a     = i_taxon_a;
                    n_b     = i_taxon_b;
                    n_state = S_FIN;
                    priority if (i_req_type == tlca_pkg::REQ_LCA) begin
                        if ((!a_neg && (i_taxon_a[NB-1:0] > r_max_node)) ||
                            (i_taxon_b > r_max_node)) begin
                            n_anc = '1;
                            n_err = 1'b1;
                        end else begin
                            tbl_addr = i_taxon_b;
                            n_state  = S_CHKB;
                        end
                    end else if (i_req_type == tlca_pkg::REQ_BLACK) begin
                        if (a_neg) begin
                            n_bl = 1'b1;
                        end else begin
                            tbl_addr = i_taxon_a[NB-1:0];
                            n_t      = i_taxon_a[NB-1:0];
                            n_n      = '0;
                            n_blk    = 1'b1;
                            n_sel    = 1'b0;
                            n_state  = S_WALK;
                        end
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_CHKB: begin
                // tbl_parent holds parent(b) here
                if ((r_b == '0) || (tbl_parent == '0)) begin
                    n_anc   = r_a;
                    n_state = S_FIN;
                end else begin
                    n_blk   = 1'b0;
                    n_n     = '0;
                    n_state = S_WALK;
                    if (r_a[TB-1]) begin
                        n_la     = '0;
                        n_sel    = 1'b1;
                        n_t      = r_b;
                        tbl_addr = r_b;
                    end else begin
                        n_sel    = 1'b0;
                        n_t      = r_a[NB-1:0];
                        tbl_addr = r_a[NB-1:0];
                    end
                end
            end
            S_WALK: begin
                if (step_go) begin
                    n_t      = tbl_parent;
                    n_n      = r_n + CW'(1);
                    tbl_addr = tbl_parent;
                    lin_we_a = !r_blk && !r_sel;
                    lin_we_b = !r_blk && r_sel;
                    if (r_blk && !tbl_allowed) begin
                        n_bl    = 1'b1;
                        n_state = S_FIN;
                    end
                end else if (r_blk) begin
                    n_bl    = 1'b0;
                    n_state = S_FIN;
                end else if (!r_sel) begin
                    // lineage of a done, start on b
                    n_la     = r_n;
                    n_sel    = 1'b1;
                    n_n      = '0;
                    n_t      = r_b;
                    tbl_addr = r_b;
                end else begin
                    n_anc = {1'b0, r_t};
                    if (m_len == '0) begin
                        n_state = S_FIN;
                    end else begin
                        n_m     = m_len;
                        n_ia    = IW'(r_la - CW'(1));
                        n_ib    = IW'(r_n - CW'(1));
                        n_state = S_CMP;
                    end
                end
            end
            S_CMP: begin
                // compare from the root end; r_xa/r_xb hold entries r_ia/r_ib
                if (r_xa == r_xb) begin
                    n_anc = {1'b0, r_xa};
                    if (r_m == CW'(1)) begin
                        n_state = S_FIN;
                    end else begin
                        n_m  = r_m - CW'(1);
                        n_ia = r_ia - IW'(1);
                        n_ib = r_ib - IW'(1);
                    end
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (fin_fire) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (fin_fire) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_max_node  <= '1;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_max_node <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sel <= n_sel;
        r_blk <= n_blk;
        r_n   <= n_n;
        r_la  <= n_la;
        r_m   <= n_m;
        r_ia  <= n_ia;
        r_ib  <= n_ib;
        r_t   <= n_t;
        r_a   <= n_a;
        r_b   <= n_b;
        r_anc <= n_anc;
        r_err <= n_err;
        r_bl  <= n_bl;
        if (fin_fire) begin
            r_out_anc <= r_anc;
            r_out_err <= r_err;
            r_out_bl  <= r_bl;
        end
    end

    // lineage stores: write at the walk count, read at the next compare index
    always_ff @(posedge i_clk) begin
        if (lin_we_a) begin
            r_lin_a[r_n[IW-1:0]] <= r_t;
        end
        if (lin_we_b) begin
            r_lin_b[r_n[IW-1:0]] <= r_t;
        end
        r_xa <= r_lin_a[n_ia];
        r_xb <= r_lin_b[n_ib];
    end

    assign o_out_valid      = r_out_valid;
    assign o_ancestor_id    = r_out_anc;
    assign o_range_error    = r_out_err;
    assign o_is_blacklisted = r_out_bl;

endmodule

@@ tb/tb_taxonomy_lca_engine.sv @@
`timescale 1ns / 1ps

module tb_taxonomy_lca_engine;

    typedef logic signed [tlca_pkg::TAXON_BITS-1:0] t_taxon;
    typedef logic [tlca_pkg::NODE_BITS-1:0]         t_node;

    // request code outside the defined set; the block answers it with zeros
    localparam logic [1:0] REQ_NONE     = 2'd3;
    localparam t_node      ALL_ONES     = {tlca_pkg::NODE_BITS{1'b1}};
    localparam int         PHASE_ITEMS  = 55;
    localparam int         PHASES       = 5;
    localparam int         DRAIN_CYCLES = 400;

    typedef struct {
        t_taxon ancestor;
        logic   range_err;
        logic   black;
    } t_answer;

    typedef struct {
        bit         cfg;      // row loads max_node from node instead of a transfer
        logic [1:0] req;
        t_node      node;
        t_node      parent;
        logic       allowed;
        t_taxon     a;
        t_node      b;
        bit         typed;    // expectation given in the row itself
        t_answer    ans;
    } t_row;

    logic   i_clk;
    logic   i_rst_n;
    logic   i_cfg_wr_en;
    t_node  i_cfg_wr_data;
    logic   i_in_valid;
    logic   o_in_stall;
    logic [1:0] i_req_type;
    t_node  i_node_id;
    t_node  i_parent_id;
    logic   i_node_allowed;
    t_taxon i_taxon_a;
    t_node  i_taxon_b;
    logic   o_out_valid;
    logic   i_out_stall = 1'b0;
    t_taxon o_ancestor_id;
    logic   o_range_error;
    logic   o_is_blacklisted;

    taxonomy_lca_engine u_top (.*);

    // predictor state: sparse copy of the tables plus the limit register
    t_node   parent_of [int];
    bit      allowed_of [int];
    t_node   max_id;
    t_node   trail_a [tlca_pkg::MAX_DEPTH];
    t_node   trail_b [tlca_pkg::MAX_DEPTH];

    t_answer pending_answers [$];
    t_node   known_nodes [$];
    t_row    script [$];
    t_answer blank;

    int  errors;
    int  n_results;
    int  n_writes;
    int  n_lca;
    int  n_range;
    int  n_black;
    int  random_sent;
    bit  calm;

    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic t_node parent_lookup(t_node n);
        if (parent_of.exists(int'(n)))
            return parent_of[int'(n)];
        return '0;
    endfunction

    function automatic bit allowed_lookup(t_node n);
        if (allowed_of.exists(int'(n)))
            return allowed_of[int'(n)];
        return 1'b0;
    endfunction

    // non-root ancestors of start, start first, capped at MAX_DEPTH
    function automatic int trace_to_root(input t_node start, input bit side_b,
                                         output t_node stop);
        t_node t;
        int    n;
        t = start;
        n = 0;
        while (n < tlca_pkg::MAX_DEPTH && parent_lookup(t) != t) begin
            if (side_b)
                trail_b[n] = t;
            else
                trail_a[n] = t;
            t = parent_lookup(t);
            n++;
        end
        stop = t;
        return n;
    endfunction

    function automatic bit lineage_excluded(t_taxon a);
        t_node t;
        int    n;
        if (a < 0)
            return 1'b1;
        t = a[tlca_pkg::NODE_BITS-1:0];
        n = 0;
        while (n < tlca_pkg::MAX_DEPTH && parent_lookup(t) != t) begin
            if (!allowed_lookup(t))
                return 1'b1;
            t = parent_lookup(t);
            n++;
        end
        return 1'b0;
    endfunction

    function automatic t_answer predict_response(logic [1:0] req, t_node node,
                                                 t_node par, logic ok, t_taxon a,
                                                 t_node b);
        t_answer r;
        t_node   stop;
        int      la, lb, m, av, bv, mx;
        bit      same;
        r.ancestor  = '0;
        r.range_err = 1'b0;
        r.black     = 1'b0;
        av = int'(a);
        bv = int'(b);
        mx = int'(max_id);
        case (req)
            tlca_pkg::REQ_WRITE: begin
                parent_of[int'(node)]  = par;
                allowed_of[int'(node)] = ok;
            end
            tlca_pkg::REQ_LCA: begin
                if ((av >= 0 && av > mx) || bv > mx) begin
                    r.ancestor  = '1;
                    r.range_err = 1'b1;
                end else if (b == '0 || parent_lookup(b) == '0) begin
                    r.ancestor = a;
                end else begin
                    la = 0;
                    if (av >= 0)
                        la = trace_to_root(a[tlca_pkg::NODE_BITS-1:0], 1'b0, stop);
                    lb = trace_to_root(b, 1'b1, stop);
                    r.ancestor = t_taxon'({1'b0, stop});
                    m = (la < lb) ? la : lb;
                    same = 1'b1;
                    // walk both lineages down from the root end
                    for (int k = 0; k < m; k++) begin
                        if (same && trail_a[la-1-k] != trail_b[lb-1-k])
                            same = 1'b0;
                        if (same)
                            r.ancestor = t_taxon'({1'b0, trail_a[la-1-k]});
                    end
                end
            end
            tlca_pkg::REQ_BLACK: r.black = lineage_excluded(a);
            default: ;
        endcase
        return r;
    endfunction

    task automatic add_row(bit cfg, logic [1:0] req, t_node node, t_node par, logic ok,
                           t_taxon a, t_node b, bit typed, t_taxon anc, logic err,
                           logic bl);
        t_row r;
        r.cfg           = cfg;
        r.req           = req;
        r.node          = node;
        r.parent        = par;
        r.allowed       = ok;
        r.a             = a;
        r.b             = b;
        r.typed         = typed;
        r.ans.ancestor  = anc;
        r.ans.range_err = err;
        r.ans.black     = bl;
        script.push_back(r);
    endtask

    // called on a rising edge; returns on the edge of the transfer or after a gap
    task automatic send_request(logic [1:0] req, t_node node, t_node par, logic ok,
                                t_taxon a, t_node b, bit typed, t_answer given);
        bit      taken;
        t_answer predicted;
        i_in_valid     <= 1'b1;
        i_req_type     <= req;
        i_node_id      <= node;
        i_parent_id    <= par;
        i_node_allowed <= ok;
        i_taxon_a      <= a;
        i_taxon_b      <= b;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = !o_in_stall;
            @(posedge i_clk);
        end
        predicted = predict_response(req, node, par, ok, a, b);
        pending_answers.push_back(typed ? given : predicted);
        case (req)
            tlca_pkg::REQ_WRITE: n_writes++;
            tlca_pkg::REQ_LCA: begin
                n_lca++;
                if (predicted.range_err)
                    n_range++;
            end
            tlca_pkg::REQ_BLACK: n_black++;
            default: ;
        endcase
        if (!calm && $urandom_range(0, 99) < 27) begin
            i_in_valid <= 1'b0;
            do
                @(posedge i_clk);
            while ($urandom_range(0, 99) < 27);
        end
    endtask

    task automatic load_max_node(t_node v);
        i_in_valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        max_id = v;
    endtask

    function automatic t_node pick_known(bit recent);
        int sz, span;
        sz = known_nodes.size();
        if (recent) begin
            span = (sz - 1 < 15) ? sz - 1 : 15;
            return known_nodes[sz - 1 - $urandom_range(0, span)];
        end
        return known_nodes[$urandom_range(0, sz - 1)];
    endfunction

    // ids past max_node are never read by the block, so they need not be written
    function automatic t_node pick_query_id();
        if (max_id != ALL_ONES && $urandom_range(0, 99) < 12)
            return t_node'($urandom_range(int'(max_id) + 1, int'(ALL_ONES)));
        return pick_known($urandom_range(0, 1) == 1);
    endfunction

    task automatic grow_chain(int len);
        t_node node;
        for (int i = 0; i < len; i++) begin
            node = t_node'($urandom);
            send_request(tlca_pkg::REQ_WRITE, node, known_nodes[$],
                         $urandom_range(0, 99) < 90, t_taxon'($urandom),
                         t_node'($urandom), 1'b0, blank);
            known_nodes.push_back(node);
            random_sent++;
        end
    endtask

    task automatic send_random();
        logic [1:0] req;
        t_node      node, par, b;
        logic       ok;
        t_taxon     a;
        int         r, p;
        node = t_node'($urandom);
        par  = t_node'($urandom);
        ok   = ($urandom_range(0, 1) == 1);
        a    = t_taxon'($urandom);
        b    = t_node'($urandom);
        r    = $urandom_range(0, 99);
        if (r < 45) begin
            req = tlca_pkg::REQ_WRITE;
            if ($urandom_range(0, 99) < 15)
                node = pick_known(1'b0);
            p = $urandom_range(0, 99);
            if (p < 8)
                par = node;
            else if (p < 65)
                par = known_nodes[$];
            else
                par = pick_known(1'b0);
            ok = $urandom_range(0, 99) < 85;
        end else if (r < 85) begin
            req = tlca_pkg::REQ_LCA;
            a   = ($urandom_range(0, 99) < 8) ? t_taxon'(-1)
                                             : t_taxon'({1'b0, pick_query_id()});
            b   = ($urandom_range(0, 99) < 5) ? t_node'(0) : pick_query_id();
        end else if (r < 97) begin
            req = tlca_pkg::REQ_BLACK;
            a   = ($urandom_range(0, 99) < 10)
                  ? t_taxon'(-1)
                  : t_taxon'({1'b0, pick_known($urandom_range(0, 1) == 1)});
        end else begin
            req = REQ_NONE;
        end
        send_request(req, node, par, ok, a, b, 1'b0, blank);
        if (req == tlca_pkg::REQ_WRITE)
            known_nodes.push_back(node);
        if (req != REQ_NONE)
            random_sent++;
    endtask

    always @(posedge i_clk)
        i_out_stall <= !calm && ($urandom_range(0, 99) < 27);

    // payload is stable at the falling edge; the transfer happens at the next rise
    always @(negedge i_clk) begin : check_results
        t_answer head;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_answers.size() == 0) begin
                $error("result with nothing outstanding: ancestor_id %0d", o_ancestor_id);
                errors++;
            end else begin
                head = pending_answers.pop_front();
                n_results++;
                if (o_ancestor_id !== head.ancestor) begin
                    $error("ancestor_id: expected %0d, got %0d", head.ancestor,
                           o_ancestor_id);
                    errors++;
                end
                if (o_range_error !== head.range_err) begin
                    $error("range_error: expected %0b, got %0b", head.range_err,
                           o_range_error);
                    errors++;
                end
                if (o_is_blacklisted !== head.black) begin
                    $error("is_blacklisted: expected %0b, got %0b", head.black,
                           o_is_blacklisted);
                    errors++;
                end
            end
        end
    end

    initial begin
        t_node limits [PHASES];
        i_rst_n        <= 1'b0;
        i_cfg_wr_en    <= 1'b0;
        i_cfg_wr_data  <= '0;
        i_in_valid     <= 1'b0;
        i_req_type     <= tlca_pkg::REQ_WRITE;
        i_node_id      <= '0;
        i_parent_id    <= '0;
        i_node_allowed <= 1'b0;
        i_taxon_a      <= '0;
        i_taxon_b      <= '0;
        max_id         = ALL_ONES;
        blank.ancestor  = '0;
        blank.range_err = 1'b0;
        blank.black     = 1'b0;
        errors = 0;
        n_results = 0;
        n_writes = 0;
        n_lca = 0;
        n_range = 0;
        n_black = 0;
        random_sent = 0;
        calm = 1'b0;

        // small tree: 0 root, 5 <- 0, 10 <- 5, 11 (excluded) and 12 <- 10,
        // two leaves with alternating bit patterns, and an excluded all-ones root
        add_row(1'b0, tlca_pkg::REQ_WRITE, 22'd0, 22'd0, 1'b1, 23'sd0, 22'd0,
                1'b1, 23'sd0, 1'b0, 1'b0);
        add_row(1'b0, tlca_pkg::REQ_WRITE, 22'd5, 22'd0, 1'b1, 23'sd0, 22'd0,
                1'b1, 23'sd0, 1'b0, 1'b0);
        add_row(1'b0, tlca_pkg::REQ_WRITE, ALL_ONES, ALL_ONES, 1'b0, 23'sd0, 22'd0,
                1'b1, 23'sd0, 1'b0, 1'b0);
        add_row(1'b0, tlca_pkg::REQ_WRITE, 22'd10, 22'd5, 1'b1, 23'sd0, 22'd0,
                1'b1, 23'sd0, 1'b0, 1'b0);
        add_row(1'b0, tlca_pkg::REQ_WRITE, 22'd11, 22'd10, 1'b0, 23'sd0, 22'd0,
                1'b1, 23'sd0, 1'b0, 1'b0);
        add_row(1'b0, tlca_pkg::REQ_WRITE, 22'd12, 22'd10, 1'b1, 23'sd0, 22'd0,
                1'b1, 23'sd0, 1'b0, 1'b0);
        add_row(1'b0, tlca_pkg::REQ_WRITE, 22'h2AAAAA, 22'd12, 1'b1, 23'sd0, 22'd0,
                1'b1, 23'sd0, 1'b0, 1'b0);
        add_row(1'b0, tlca_pkg::REQ_WRITE, 22'h155555, 22'd11, 1'b1, 23'sd0, 22'd0,
                1'b1, 23'sd0, 1'b0, 1'b0);
        // early answers
        add_row(1'b0, tlca_pkg::REQ_LCA, 22'd0, 22'd0, 1'b0, -23'sd1, 22'd0,
                1'b1, -23'sd1, 1'b0, 1'b0);
        add_row(1'b0, tlca_pkg::REQ_LCA, 22'd0, 22'd0, 1'b0, 23'sd12, 22'd0,
                1'b1, 23'sd12, 1'b0, 1'b0);
        add_row(1'b0, tlca_pkg::REQ_LCA, 22'd0, 22'd0, 1'b0, 23'sd11, 22'd5,
                1'b1, 23'sd11, 1'b0, 1'b0);
        // full walks: shared branch, unassigned a, root a, both roots
        add_row(1'b0, tlca_pkg::REQ_LCA, 22'd0, 22'd0, 1'b0, 23'sh2AAAAA, 22'h155555,
                1'b0, 23'sd0, 1'b0, 1'b0);
        add_row(1'b0, tlca_pkg::REQ_LCA, 22'd0, 22'd0, 1'b0, -23'sd1, 22'h155555,
                1'b0, 23'sd0, 1'b0, 1'b0);
        add_row(1'b0, tlca_pkg::REQ_LCA, 22'd0, 22'd0, 1'b0, 23'sh3FFFFF, 22'd10,
                1'b0, 23'sd0, 1'b0, 1'b0);
        add_row(1'b0, tlca_pkg::REQ_LCA, 22'd0, 22'd0, 1'b0, 23'sh3FFFFF, ALL_ONES,
                1'b0, 23'sd0, 1'b0, 1'b0);
        add_row(1'b0, tlca_pkg::REQ_BLACK, 22'd0, 22'd0, 1'b0, -23'sd1, 22'd0,
                1'b1, 23'sd0, 1'b0, 1'b1);
        add_row(1'b0, tlca_pkg::REQ_BLACK, 22'd0, 22'd0, 1'b0, 23'sh155555, 22'd0,
                1'b0, 23'sd0, 1'b0, 1'b0);
        add_row(1'b0, tlca_pkg::REQ_BLACK, 22'd0, 22'd0, 1'b0, 23'sh2AAAAA, 22'd0,
                1'b0, 23'sd0, 1'b0, 1'b0);
        add_row(1'b0, tlca_pkg::REQ_BLACK, 22'd0, 22'd0, 1'b0, 23'sh3FFFFF, 22'd0,
                1'b0, 23'sd0, 1'b0, 1'b0);
        add_row(1'b0, REQ_NONE, 22'd7, 22'd9, 1'b1, 23'sd3, 22'd5,
                1'b1, 23'sd0, 1'b0, 1'b0);
        // range errors on either side
        add_row(1'b1, tlca_pkg::REQ_WRITE, 22'h200000, 22'd0, 1'b0, 23'sd0, 22'd0,
                1'b0, 23'sd0, 1'b0, 1'b0);
        add_row(1'b0, tlca_pkg::REQ_LCA, 22'd0, 22'd0, 1'b0, 23'sh2AAAAA, 22'd10,
                1'b1, -23'sd1, 1'b1, 1'b0);
        add_row(1'b0, tlca_pkg::REQ_LCA, 22'd0, 22'd0, 1'b0, 23'sd10, ALL_ONES,
                1'b1, -23'sd1, 1'b1, 1'b0);
        add_row(1'b0, tlca_pkg::REQ_LCA, 22'd0, 22'd0, 1'b0, -23'sd1, 22'h2AAAAA,
                1'b1, -23'sd1, 1'b1, 1'b0);
        add_row(1'b1, tlca_pkg::REQ_WRITE, 22'd0, 22'd0, 1'b0, 23'sd0, 22'd0,
                1'b0, 23'sd0, 1'b0, 1'b0);
        add_row(1'b0, tlca_pkg::REQ_LCA, 22'd0, 22'd0, 1'b0, -23'sd1, 22'd0,
                1'b1, -23'sd1, 1'b0, 1'b0);
        add_row(1'b0, tlca_pkg::REQ_LCA, 22'd0, 22'd0, 1'b0, 23'sd0, 22'd0,
                1'b1, 23'sd0, 1'b0, 1'b0);
        add_row(1'b0, tlca_pkg::REQ_LCA, 22'd0, 22'd0, 1'b0, 23'sd5, 22'd0,
                1'b1, -23'sd1, 1'b1, 1'b0);
        add_row(1'b0, tlca_pkg::REQ_BLACK, 22'd0, 22'd0, 1'b0, 23'sh2AAAAA, 22'd0,
                1'b0, 23'sd0, 1'b0, 1'b0);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[i]) begin
            if (script[i].cfg) begin
                load_max_node(script[i].node);
            end else begin
                send_request(script[i].req, script[i].node, script[i].parent,
                             script[i].allowed, script[i].a, script[i].b,
                             script[i].typed, script[i].ans);
                if (script[i].req == tlca_pkg::REQ_WRITE)
                    known_nodes.push_back(script[i].node);
            end
        end

        limits[0] = ALL_ONES;
        limits[1] = t_node'($urandom);
        limits[2] = '0;
        limits[3] = t_node'($urandom_range(0, 22'h200000));
        limits[4] = ALL_ONES;
        for (int ph = 0; ph < PHASES; ph++) begin
            load_max_node(limits[ph]);
            calm = (ph == 1);
            // first chain runs past MAX_DEPTH so the walk limit is exercised
            grow_chain(ph == 0 ? tlca_pkg::MAX_DEPTH + 10 : $urandom_range(5, 30));
            while (random_sent < (ph + 1) * PHASE_ITEMS + tlca_pkg::MAX_DEPTH) begin
                if ($urandom_range(0, 99) < 10)
                    grow_chain($urandom_range(2, 8));
                else
                    send_random();
            end
        end
        calm = 1'b0;

        i_in_valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_answers.size() != 0) begin
            $error("%0d results never arrived", pending_answers.size());
            errors++;
        end

        $display("covered %0d node writes, %0d ancestor queries (%0d out of range),",
                 n_writes, n_lca, n_range);
        $display("%0d blacklist queries; %0d results checked across %0d max_node loads",
                 n_black, n_results, PHASES + 2);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
